FILE: rtl/core/srrw_pkg.sv
// Shared types and constants of the selective-repeat receive window.
// No dependencies; used by srrw_ctrl, srrw_dp and the top level.
package srrw_pkg;

	localparam int SEQ_W   = 16;
	localparam int BYTES_W = 11;
	localparam int NEXT_W  = 17;
	localparam int LEN_W   = 27;
	localparam int WIN_W   = 6;
	localparam int BUFN_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WIN_SPAN      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_FRAMES = 1'b1;

	localparam logic [WIN_W-1:0]  WINDOW_RESET = 6'd8;
	localparam logic [BUFN_W-1:0] BUFFER_RESET = 16'd64;
	localparam logic [LEN_W-1:0]  LEN_MAX      = {LEN_W{1'b1}};

	typedef struct packed {
		logic [SEQ_W-1:0]   seq_num;
		logic               checksum_ok;
		logic               end_of_transfer;
		logic [BYTES_W-1:0] payload_bytes;
	} frame_word_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  ack_seq;
		logic              ack_good;
		logic              store_payload;
		logic              in_order;
		logic [NEXT_W-1:0] next_expected;
		logic              buffer_done;
		logic              transfer_done;
		logic [LEN_W-1:0]  final_bytes;
	} ack_word_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic scan;
		logic mul;
		logic resp;
	} cmd_t;

	typedef struct packed {
		logic scan_more;
	} status_t;

endpackage

FILE: rtl/core/srrw_ctrl.sv
// Controller of the receive window: sequences load, evaluate, scan and respond.
// Depends on srrw_pkg.
module srrw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	output logic                frame_stall,
	input  logic                ack_stall,
	output logic                ack_valid,
	input  srrw_pkg::status_t   status,
	output srrw_pkg::cmd_t      cmd
);

	srrw_pkg::state_t state_q, state_nx;
	logic             ack_valid_q;
	logic             resp_ok;

	assign resp_ok     = !ack_valid_q || !ack_stall;
	assign frame_stall = (state_q != srrw_pkg::S_IDLE);
	assign ack_valid   = ack_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			srrw_pkg::S_IDLE: begin
				if (frame_valid) state_nx = srrw_pkg::S_EVAL;
			end
			srrw_pkg::S_EVAL: state_nx = srrw_pkg::S_SCAN;
			srrw_pkg::S_SCAN: begin
				if (!status.scan_more) state_nx = srrw_pkg::S_RESP;
			end
			srrw_pkg::S_RESP: begin
				if (resp_ok) state_nx = srrw_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			srrw_pkg::S_IDLE: cmd.load = frame_valid;
			srrw_pkg::S_EVAL: cmd.eval = 1'b1;
			srrw_pkg::S_SCAN: begin
				cmd.scan = status.scan_more;
				cmd.mul  = !status.scan_more;
			end
			srrw_pkg::S_RESP: cmd.resp = resp_ok;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srrw_pkg::S_IDLE;
			ack_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.resp) ack_valid_q <= 1'b1;
			else if (!ack_stall) ack_valid_q <= 1'b0;
		end
	end

	// a new ack word appears only out of the respond step
	a_ack_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ack_valid) |-> $past(state_q == srrw_pkg::S_RESP))
		else $error("ack_valid rose outside the respond step");

	// a held ack blocks the next response
	a_resp_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srrw_pkg::S_RESP && ack_valid && ack_stall) |=>
		(state_q == srrw_pkg::S_RESP))
		else $error("response overwrote a stalled ack word");

endmodule

FILE: rtl/core/srrw_dp.sv
// Datapath of the receive window: window state, received map, length multiplier.
// Depends on srrw_pkg; driven by commands from srrw_ctrl.
module srrw_dp #(
	parameter int MAX_WINDOW    = 32,
	parameter int FRAME_PAYLOAD = 1024,
	parameter int SEQ_WIDTH     = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  srrw_pkg::frame_word_t                frame,
	input  logic                                 cfg_we,
	input  logic [srrw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srrw_pkg::CFG_W-1:0]           cfg_data,
	input  srrw_pkg::cmd_t                       cmd,
	output srrw_pkg::status_t                    status,
	output srrw_pkg::ack_word_t                  ack
);

	localparam int MAPW     = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
	localparam int IDXW     = (MAPW > 1) ? $clog2(MAPW) : 1;
	localparam int SEQ_KEEP = (SEQ_WIDTH < srrw_pkg::SEQ_W) ? SEQ_WIDTH : srrw_pkg::SEQ_W;
	localparam logic [srrw_pkg::SEQ_W-1:0] SEQ_MASK =
		srrw_pkg::SEQ_W'((64'd1 << SEQ_KEEP) - 64'd1);
	localparam int FPW  = $clog2(FRAME_PAYLOAD + 1);
	localparam int PW   = srrw_pkg::SEQ_W + FPW;
	localparam int SUMW = (PW + 1 > srrw_pkg::LEN_W + 1) ? PW + 1 : srrw_pkg::LEN_W + 1;
	localparam logic [FPW-1:0] FP = FPW'(FRAME_PAYLOAD);

	// clamp to 1..MAPW
	function automatic logic [srrw_pkg::WIN_W-1:0] eff_window(
		input logic [srrw_pkg::WIN_W-1:0] w
	);
		logic [srrw_pkg::WIN_W-1:0] r;
		r = w;
		if (r == '0) r = srrw_pkg::WIN_W'(1);
		if (r > srrw_pkg::WIN_W'(MAPW)) r = srrw_pkg::WIN_W'(MAPW);
		return r;
	endfunction

	function automatic logic [MAPW-1:0] win_mask(input logic [srrw_pkg::WIN_W-1:0] w);
		logic [MAPW-1:0] m;
		for (int i = 0; i < MAPW; i++) m[i] = (i < int'(w));
		return m;
	endfunction

	// control state
	logic [srrw_pkg::WIN_W-1:0]  win_q;
	logic [srrw_pkg::BUFN_W-1:0] bufn_q;
	logic [srrw_pkg::NEXT_W-1:0] next_q;
	logic [MAPW-1:0]             map_q;
	logic [srrw_pkg::NEXT_W-1:0] fib_q;
	logic                        last_q;
	logic                        fin_q;

	// per-word payload
	srrw_pkg::frame_word_t        item_q;
	logic                         store_q;
	logic                         inord_q;
	logic                         done_q;
	logic [srrw_pkg::BYTES_W-1:0] eot_bytes_q;
	logic [PW-1:0]                prod_s1;
	srrw_pkg::ack_word_t          ack_q;

	logic [srrw_pkg::WIN_W-1:0]  w_eff;
	logic [srrw_pkg::NEXT_W-1:0] seq17;
	logic                        in_win;
	logic                        hit;
	logic                        hit_next;
	logic                        hit_ahead;
	logic [srrw_pkg::NEXT_W-1:0] ahead;
	logic [IDXW-1:0]             idx;
	logic                        mark_new;
	logic                        eot_hit;
	logic [srrw_pkg::SEQ_W-1:0]  mul_op;
	logic [srrw_pkg::BYTES_W-1:0] add_b;
	logic [SUMW-1:0]             len_sum;
	logic [srrw_pkg::LEN_W-1:0]  len_sat;
	logic                        buf_end;
	logic [MAPW-1:0]             cfg_mask;
	logic                        untouched;

	always_comb begin
		w_eff     = eff_window(win_q);
		seq17     = {1'b0, item_q.seq_num};
		in_win    = {1'b0, seq17} < ({1'b0, next_q} + 18'(w_eff));
		hit       = !fin_q && in_win && item_q.checksum_ok;
		hit_next  = hit && (seq17 == next_q);
		hit_ahead = hit && (seq17 > next_q);
		ahead     = seq17 - next_q;
		idx       = ahead[IDXW-1:0];
		mark_new  = hit_ahead && !map_q[idx];
		eot_hit   = hit && item_q.end_of_transfer;
		// with the end mark, fib = seq + 1 so fib - 1 fits the sequence width
		mul_op    = last_q ? srrw_pkg::SEQ_W'(fib_q - 1'b1) : fib_q[srrw_pkg::SEQ_W-1:0];
		add_b     = last_q ? eot_bytes_q : '0;
		len_sum   = SUMW'(prod_s1) + SUMW'(add_b);
		len_sat   = (len_sum > SUMW'(srrw_pkg::LEN_MAX)) ? srrw_pkg::LEN_MAX :
			len_sum[srrw_pkg::LEN_W-1:0];
		buf_end   = !fin_q && (next_q >= fib_q);
		cfg_mask  = win_mask(eff_window(cfg_data[srrw_pkg::WIN_W-1:0]));
		untouched = (next_q == '0) && (map_q == '0) && !last_q && !fin_q;
	end

	assign status.scan_more = inord_q && map_q[0];
	assign ack = ack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= srrw_pkg::WINDOW_RESET;
			bufn_q <= srrw_pkg::BUFFER_RESET;
			next_q <= '0;
			map_q  <= '0;
			fib_q  <= srrw_pkg::NEXT_W'(srrw_pkg::BUFFER_RESET);
			last_q <= 1'b0;
			fin_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srrw_pkg::REG_WIN_SPAN: begin
					win_q <= cfg_data[srrw_pkg::WIN_W-1:0];
					map_q <= map_q & cfg_mask;
				end
				srrw_pkg::REG_BUFFER_FRAMES: begin
					bufn_q <= cfg_data[srrw_pkg::BUFN_W-1:0];
					if (untouched) fib_q <= srrw_pkg::NEXT_W'(cfg_data);
				end
			endcase
		end else begin
			if (cmd.eval) begin
				if (hit_next) begin
					map_q  <= map_q >> 1;
					next_q <= next_q + 1'b1;
				end else if (mark_new) begin
					map_q[idx] <= 1'b1;
				end
				if (eot_hit) begin
					fib_q  <= seq17 + 1'b1;
					last_q <= 1'b1;
				end
			end
			if (cmd.scan) begin
				map_q  <= map_q >> 1;
				next_q <= next_q + 1'b1;
			end
			if (cmd.resp && done_q) begin
				if (last_q) begin
					fin_q <= 1'b1;
				end else begin
					next_q <= '0;
					map_q  <= '0;
					fib_q  <= srrw_pkg::NEXT_W'(bufn_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q.seq_num         <= frame.seq_num & SEQ_MASK;
			item_q.checksum_ok     <= frame.checksum_ok;
			item_q.end_of_transfer <= frame.end_of_transfer;
			item_q.payload_bytes   <= frame.payload_bytes;
		end
		if (cmd.eval) begin
			store_q <= hit_next || mark_new;
			inord_q <= hit_next;
			if (eot_hit) eot_bytes_q <= item_q.payload_bytes;
		end
		if (cmd.mul) begin
			done_q  <= buf_end;
			prod_s1 <= PW'(mul_op) * PW'(FP);
		end
		if (cmd.resp) begin
			ack_q.ack_seq       <= item_q.seq_num;
			ack_q.ack_good      <= item_q.checksum_ok;
			ack_q.store_payload <= store_q;
			ack_q.in_order      <= inord_q;
			ack_q.next_expected <= (done_q && !last_q) ? '0 : next_q;
			ack_q.buffer_done   <= done_q;
			ack_q.transfer_done <= fin_q || (done_q && last_q);
			ack_q.final_bytes   <= done_q ? len_sat : '0;
		end
	end

	a_map_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(map_q & ~win_mask(eff_window(win_q))) == '0)
		else $error("received mark outside the window");

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("transfer end cleared");

	a_fin_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> last_q)
		else $error("transfer ended without an end mark");

endmodule

FILE: rtl/core/selective_repeat_receive_window.sv
// Top level of the selective-repeat receive window.
// Depends on srrw_pkg, srrw_ctrl and srrw_dp.
//
// Usage:
//  - frame channel (frame_valid/frame_stall/frame): one received frame header per word.
//  - ack channel (ack_valid/ack_stall/ack): one ack word per frame word, in order,
//    with store/in-order flags, next expected number and buffer/transfer status.
//  - cfg_we/cfg_index/cfg_data: write the window span (index 0) or buffer_frames
//    (index 1); write only while no frame is in flight.
//  - ack_valid rises out of the respond step, after the evaluate step and a scan that
//    slides over each already-received frame (up to the window span - 1); a new frame
//    is taken only once the previous one has left its respond step.
//  - The buffer byte length comes from one multiplier, registered before the add.
//  - frame_stall is high while a frame is being processed; the next frame is
//    taken as soon as the previous ack sits in the output register.
//  - If ack_stall holds the output word, the block finishes the next frame up to
//    its response step and waits there.
//  - Reset: window 8, 64 frames per buffer, empty window at frame 0, no ack pending.
//  - After the end-of-transfer buffer completes, every frame is still acked but
//    nothing is stored and transfer_done stays set until reset.
module selective_repeat_receive_window #(
	parameter int MAX_WINDOW    = 32,
	parameter int FRAME_PAYLOAD = 1024,
	parameter int SEQ_WIDTH     = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            frame_valid,
	output logic                            frame_stall,
	input  srrw_pkg::frame_word_t           frame,
	output logic                            ack_valid,
	input  logic                            ack_stall,
	output srrw_pkg::ack_word_t             ack,
	input  logic                            cfg_we,
	input  logic [srrw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srrw_pkg::CFG_W-1:0]      cfg_data
);

	srrw_pkg::cmd_t    cmd;
	srrw_pkg::status_t status;

	// sequencer: one frame at a time
	srrw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.ack_stall   (ack_stall),
		.ack_valid   (ack_valid),
		.status      (status),
		.cmd         (cmd)
	);

	// window state, received map, length math and ack register
	srrw_dp #(
		.MAX_WINDOW    (MAX_WINDOW),
		.FRAME_PAYLOAD (FRAME_PAYLOAD),
		.SEQ_WIDTH     (SEQ_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.ack       (ack)
	);

endmodule

FILE: bench/tb_selective_repeat_receive_window.sv
// Testbench of the selective-repeat receive window: directed and random frame words
// checked field by field against an untimed window predictor, random idling on both channels.
// Depends on srrw_pkg and the selective_repeat_receive_window RTL.
module tb_selective_repeat_receive_window;

	localparam int MAX_WINDOW   = 32;
	localparam int FRAME_BYTES  = 1024;
	localparam int SEQ_BITS     = 16;
	localparam int RANDOM_WORDS = 2000;
	localparam int QUIET_LIMIT  = 4000;  // well above hold-off + scan + longest gap
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;    // covers a full response with a scan over up to 31 held frames, with margin

	// Architectural state of the window plus the two config registers.
	typedef struct packed {
		logic [srrw_pkg::WIN_W-1:0]  win_reg;
		logic [srrw_pkg::BUFN_W-1:0] bufn_reg;
		logic [srrw_pkg::NEXT_W-1:0] next_frame;
		logic [31:0]                 rx_map;      // bit i: frame next_frame+i already held
		logic [srrw_pkg::NEXT_W-1:0] buf_frames;
		logic [srrw_pkg::LEN_W-1:0]  buf_len;
		logic                        eot_seen;
		logic                        done;
	} window_state_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           frame_valid = 1'b0;
	logic                           frame_stall;
	srrw_pkg::frame_word_t          frame       = '0;
	logic                           ack_valid;
	logic                           ack_stall   = 1'b0;
	srrw_pkg::ack_word_t            ack;
	logic                           cfg_we      = 1'b0;
	logic [srrw_pkg::CFG_IDX_W-1:0] cfg_index   = srrw_pkg::REG_WIN_SPAN;
	logic [srrw_pkg::CFG_W-1:0]     cfg_data    = '0;

	srrw_pkg::frame_word_t frame_q[$];    // words waiting for the driver
	srrw_pkg::ack_word_t   ack_due_q[$];  // predicted acks, oldest first
	srrw_pkg::ack_word_t   next_due;
	// live_win follows accepted words; plan_win runs ahead at generation time
	// so the stimulus can aim at the current window.
	window_state_t live_win, plan_win;

	int frames_issued = 0;
	int acks_taken    = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;
	int gap_left      = 0;
	int stall_left    = 0;
	int hold_left     = 0;
	bit tx_gaps_on    = 1'b1;
	bit rx_stalls_on  = 1'b1;
	bit hold_req      = 1'b0;
	bit hold_taken    = 1'b0;

	selective_repeat_receive_window #(
		.MAX_WINDOW(MAX_WINDOW),
		.FRAME_PAYLOAD(FRAME_BYTES),
		.SEQ_WIDTH(SEQ_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame),
		.ack_valid(ack_valid),
		.ack_stall(ack_stall),
		.ack(ack),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// Register value 0 behaves as 1, anything past the map width clamps.
	function automatic int window_span(input window_state_t s);
		int w;
		w = s.win_reg;
		if (w < 1)
			w = 1;
		if (w > MAX_WINDOW)
			w = MAX_WINDOW;
		if (w > 32)
			w = 32;
		return w;
	endfunction

	function automatic logic [srrw_pkg::LEN_W-1:0] clip_len(input longint v);
		return (v > srrw_pkg::LEN_MAX) ? srrw_pkg::LEN_MAX : srrw_pkg::LEN_W'(v);
	endfunction

	function automatic void restart_buffer(inout window_state_t s);
		s.next_frame = '0;
		s.rx_map     = '0;
		s.buf_frames = s.bufn_reg;
		s.buf_len    = clip_len(longint'(s.bufn_reg) * FRAME_BYTES);
	endfunction

	function automatic window_state_t reset_state();
		window_state_t s;
		s = '0;
		s.win_reg  = srrw_pkg::WINDOW_RESET;
		s.bufn_reg = srrw_pkg::BUFFER_RESET;
		restart_buffer(s);
		return s;
	endfunction

	function automatic void apply_reg(inout window_state_t s,
			input logic [srrw_pkg::CFG_IDX_W-1:0] idx,
			input logic [srrw_pkg::CFG_W-1:0] data);
		logic [63:0] keep;
		if (idx == srrw_pkg::REG_WIN_SPAN) begin
			// shrinking forgets marks that fall past the new window
			s.win_reg = data[srrw_pkg::WIN_W-1:0];
			keep = (64'd1 << window_span(s)) - 64'd1;
			s.rx_map &= keep[31:0];
		end else begin
			// frame count reloads only into a buffer nobody has touched yet
			s.bufn_reg = data[srrw_pkg::BUFN_W-1:0];
			if (s.next_frame == 0 && s.rx_map == 0 && !s.eot_seen && !s.done)
				restart_buffer(s);
		end
	endfunction

	function automatic srrw_pkg::ack_word_t predict_ack(inout window_state_t s,
			input srrw_pkg::frame_word_t f);
		srrw_pkg::ack_word_t a;
		int w, seq, nf, shift, i;
		a   = '0;
		w   = window_span(s);
		seq = f.seq_num;
		nf  = s.next_frame;
		if (!s.done) begin
			// old frames pass the bound too; only their end mark matters
			if (f.checksum_ok && seq < nf + w) begin
				if (seq == nf) begin
					// slide over the run of frames already held
					shift = 1;
					for (i = 1; i < w && s.rx_map[i]; i++)
						shift++;
					s.rx_map        = s.rx_map >> shift;
					s.next_frame    = nf + shift;
					a.store_payload = 1'b1;
					a.in_order      = 1'b1;
				end else if (seq > nf && !s.rx_map[seq - nf]) begin
					s.rx_map[seq - nf] = 1'b1;
					a.store_payload    = 1'b1;
				end
				if (f.end_of_transfer) begin
					s.buf_len    = clip_len(longint'(seq) * FRAME_BYTES + f.payload_bytes);
					s.buf_frames = seq + 1;
					s.eot_seen   = 1'b1;
				end
			end
			if (s.next_frame >= s.buf_frames) begin
				a.buffer_done = 1'b1;
				a.final_bytes = s.buf_len;
				if (s.eot_seen)
					s.done = 1'b1;
				else
					restart_buffer(s);
			end
		end
		a.ack_seq       = f.seq_num;
		a.ack_good      = f.checksum_ok;
		a.next_expected = s.next_frame;
		a.transfer_done = s.done;
		return a;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch at ack %0d: %s got %0h want %0h", acks_taken, what, got, want);
	endtask

	task automatic check_ack(input srrw_pkg::ack_word_t got, input srrw_pkg::ack_word_t want);
		if (got.ack_seq !== want.ack_seq)
			report_mismatch("ack_seq", got.ack_seq, want.ack_seq);
		if (got.ack_good !== want.ack_good)
			report_mismatch("ack_good", got.ack_good, want.ack_good);
		if (got.store_payload !== want.store_payload)
			report_mismatch("store_payload", got.store_payload, want.store_payload);
		if (got.in_order !== want.in_order)
			report_mismatch("in_order", got.in_order, want.in_order);
		if (got.next_expected !== want.next_expected)
			report_mismatch("next_expected", got.next_expected, want.next_expected);
		if (got.buffer_done !== want.buffer_done)
			report_mismatch("buffer_done", got.buffer_done, want.buffer_done);
		if (got.transfer_done !== want.transfer_done)
			report_mismatch("transfer_done", got.transfer_done, want.transfer_done);
		if (got.final_bytes !== want.final_bytes)
			report_mismatch("final_bytes", got.final_bytes, want.final_bytes);
	endtask

	// Frame words are predicted when accepted; ack words are checked when accepted.
	// Both sample pre-edge values, so ordering inside the time step is irrelevant.
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_valid && !frame_stall) begin
				next_due = predict_ack(live_win, frame);
				ack_due_q.push_back(next_due);
			end
			if (ack_valid && !ack_stall) begin
				acks_taken++;
				if (ack_due_q.size() == 0)
					report_mismatch("ack word with nothing pending", ack.ack_seq, 0);
				else
					check_ack(ack, ack_due_q.pop_front());
			end
			if ((frame_valid && !frame_stall) || (ack_valid && !ack_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Hung handshake: nothing accepted for too long.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb_selective_repeat_receive_window NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------- channels

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Frame driver: a new word only once the current one is taken; valid holds under stall.
	always @(posedge clk) begin
		if (arst_n && (!frame_valid || !frame_stall)) begin
			if (gap_left > 0) begin
				gap_left--;
				frame_valid <= 1'b0;
			end else if (frame_q.size() > 0) begin
				frame       <= frame_q.pop_front();
				frame_valid <= 1'b1;
				gap_left = tx_gaps_on ? draw_gap() : 0;
			end else begin
				frame_valid <= 1'b0;
			end
		end
	end

	// Ack receiver: random stalls, plus one long hold-off on request so the
	// block backs up and stalls the frame channel.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			ack_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			ack_stall <= 1'b1;
		end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
			stall_left = draw_gap();
			ack_stall <= 1'b1;
		end else begin
			ack_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- stimulus

	// Register writes only with every issued word acked, i.e. the block idle.
	task automatic set_reg(input logic [srrw_pkg::CFG_IDX_W-1:0] idx,
			input logic [srrw_pkg::CFG_W-1:0] data);
		wait (acks_taken == frames_issued);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		apply_reg(live_win, idx, data);
		apply_reg(plan_win, idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send(input int seq, input bit ok, input bit eot, input int nbytes);
		srrw_pkg::frame_word_t f;
		srrw_pkg::ack_word_t   ignored;
		f.seq_num         = seq;
		f.checksum_ok     = ok;
		f.end_of_transfer = eot;
		f.payload_bytes   = nbytes;
		ignored = predict_ack(plan_win, f);
		frame_q.push_back(f);
		frames_issued++;
	endtask

	function automatic int draw_bytes();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return FRAME_BYTES;
			2: return 2047;
			default: return $urandom_range(0, 2047);
		endcase
	endfunction

	// Mostly a sender working through the window; the rest is nacks, stale
	// retransmits and stray numbers. End marks only where they have no effect,
	// so the transfer stays open until the closing phase.
	task automatic send_random_frame();
		int w, nf, seq, pick;
		bit ok, eot;
		w    = window_span(plan_win);
		nf   = plan_win.next_frame;
		pick = $urandom_range(0, 99);
		ok   = 1'b1;
		eot  = 1'b0;
		if (plan_win.done) begin
			seq = $urandom_range(0, 65535);
			ok  = $urandom_range(0, 1);
			eot = $urandom_range(0, 1);
		end else if (pick < 30) begin
			seq = nf;
		end else if (pick < 72) begin
			seq = nf + $urandom_range(0, w - 1);
		end else if (pick < 80) begin
			seq = nf + $urandom_range(0, w + 3);
			ok  = 1'b0;
			eot = $urandom_range(0, 1);
		end else if (pick < 87 && nf > 0) begin
			seq = $urandom_range(0, nf - 1);
		end else if (pick < 94) begin
			seq = nf + w + $urandom_range(0, 7);
			eot = $urandom_range(0, 1);
		end else begin
			seq = $urandom_range(0, 65535);
			ok  = $urandom_range(0, 1);
			eot = ($urandom_range(0, 1) == 1) && (!ok || seq >= nf + w);
		end
		if (seq > 65535) begin
			// wrapped numbers may land in the window; keep them harmless
			seq = seq & 16'hFFFF;
			ok  = 1'b0;
		end
		send(seq, ok, eot, draw_bytes());
	endtask

	function automatic logic [srrw_pkg::CFG_W-1:0] pick_window();
		logic [srrw_pkg::CFG_W-1:0] d;
		d = $urandom;  // upper bits are don't-care but get toggled
		case ($urandom_range(0, 9))
			0: d[srrw_pkg::WIN_W-1:0] = 0;
			1: d[srrw_pkg::WIN_W-1:0] = 1;
			2: d[srrw_pkg::WIN_W-1:0] = 32;
			3: d[srrw_pkg::WIN_W-1:0] = $urandom_range(33, 63);
			default: d[srrw_pkg::WIN_W-1:0] = $urandom_range(2, 31);
		endcase
		return d;
	endfunction

	function automatic logic [srrw_pkg::CFG_W-1:0] pick_buffer();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return 1;
		if (r == 2)
			return $urandom_range(200, 600);
		return $urandom_range(2, 40);
	endfunction

	initial begin
		int phase, n, w, nf, seq, base, guard;
		live_win = reset_state();
		plan_win = reset_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: full-width frame count reload, then a 3-frame buffer.
		set_reg(srrw_pkg::REG_BUFFER_FRAMES, 16'hFFFF);
		set_reg(srrw_pkg::REG_BUFFER_FRAMES, 16'd3);
		send(0, 1, 0, 0);
		send(2, 1, 0, 2047);          // ahead of window base, marked
		send(2, 1, 0, FRAME_BYTES);   // duplicate, acked only
		send(1, 1, 0, FRAME_BYTES);   // fills the hole, slides, completes buffer
		send(1, 1, 0, 5);
		send(65535, 1, 1, 2047);      // far past the window, end mark ignored
		send(0, 0, 1, 0);             // bad checksum carrying an end mark
		send(7, 1, 0, 17);            // top slot of window 8
		send(8, 1, 0, 33);            // first slot past it
		// window register above the limit clamps; frame count 0 waits for next buffer
		set_reg(srrw_pkg::REG_WIN_SPAN, 16'hFFFF);
		set_reg(srrw_pkg::REG_BUFFER_FRAMES, 16'd0);
		send(31, 1, 0, 100);
		send(0, 1, 0, 200);
		send(2, 1, 0, 300);           // completes; next buffer is zero frames long
		send(4, 1, 0, 400);           // zero-frame buffer completes on any word
		set_reg(srrw_pkg::REG_BUFFER_FRAMES, 16'd6);
		set_reg(srrw_pkg::REG_WIN_SPAN, 16'd0);   // acts as a window of one
		send(0, 1, 0, 1);
		send(2, 1, 0, 2);
		send(0, 1, 0, 3);             // stale frame
		set_reg(srrw_pkg::REG_WIN_SPAN, 16'd32);
		send(10, 1, 0, 4);
		send(20, 1, 0, 5);
		set_reg(srrw_pkg::REG_WIN_SPAN, 16'd4);   // shrink drops the far marks
		send(1, 1, 0, 6);
		send(2, 1, 0, 7);

		// Random phases with fresh settings and idling modes.
		base  = frames_issued;
		phase = 0;
		while (frames_issued - base < RANDOM_WORDS) begin
			if ($urandom_range(0, 2) == 0)
				set_reg(srrw_pkg::REG_WIN_SPAN, pick_window());
			if ($urandom_range(0, 2) == 0)
				set_reg(srrw_pkg::REG_BUFFER_FRAMES, pick_buffer());
			tx_gaps_on   = $urandom_range(0, 3) != 0;
			rx_stalls_on = $urandom_range(0, 3) != 0;
			n = $urandom_range(20, 120);
			if (phase == 2) begin
				// back-pressure: sender streams while the receiver holds off
				tx_gaps_on = 1'b0;
				hold_req   = 1'b1;
				n          = 60;
			end
			repeat (n) send_random_frame();
			phase++;
		end

		// Closing phase: one good end-marked frame, then run until the transfer ends.
		set_reg(srrw_pkg::REG_WIN_SPAN, pick_window());
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		w  = window_span(plan_win);
		nf = plan_win.next_frame;
		if (nf > 0 && $urandom_range(0, 1) == 1)
			seq = $urandom_range(0, nf - 1);   // stale frame ends the buffer at once
		else
			seq = nf + $urandom_range(0, w - 1);
		send(seq, 1, 1, draw_bytes());
		guard = 0;
		while (!plan_win.done && guard < 3000) begin
			send_random_frame();
			guard++;
		end
		// after the transfer everything is acked and nothing stored
		repeat (30) send_random_frame();

		wait (acks_taken == frames_issued);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && ack_due_q.size() == 0)
			$display("tb_selective_repeat_receive_window OK");
		else
			$display("tb_selective_repeat_receive_window NOT OK");
		$finish;
	end

endmodule
